// File: hdl/button_dimmer_controller_core_defines.svh
// ----------------------------------------------------------------------------
// button dimmer controller assertion macros
// shared concurrent check forms for the dimmer core
// ----------------------------------------------------------------------------
`ifndef BUTTON_DIMMER_CONTROLLER_CORE_DEFINES_SVH
`define BUTTON_DIMMER_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BDC_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("bdc same-cycle check failed");

// next-cycle implication, checked out of reset
`define BDC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("bdc next-cycle check failed");

`endif

// File: hdl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// types, register indexes and reset values of the push-button dimmer
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam int CntW  = 16;
  localparam int LevelW = 8;
  localparam int IdxW  = 3;

  localparam logic [CntW-1:0] CNT_MAX = '1;

  localparam logic [IdxW-1:0] REG_DEBOUNCE_MS    = 3'd0;
  localparam logic [IdxW-1:0] REG_SHORT_PRESS_MS = 3'd1;
  localparam logic [IdxW-1:0] REG_LONG_PRESS_MS  = 3'd2;
  localparam logic [IdxW-1:0] REG_RAMP_PERIOD_MS = 3'd3;
  localparam logic [IdxW-1:0] REG_MIN_LEVEL      = 3'd4;
  localparam logic [IdxW-1:0] REG_MAX_LEVEL      = 3'd5;

  localparam logic [CntW-1:0]   RST_DEBOUNCE_MS    = 16'd60;
  localparam logic [CntW-1:0]   RST_SHORT_PRESS_MS = 16'd500;
  localparam logic [CntW-1:0]   RST_LONG_PRESS_MS  = 16'd3000;
  localparam logic [CntW-1:0]   RST_RAMP_PERIOD_MS = 16'd10;
  localparam logic [LevelW-1:0] RST_MIN_LEVEL      = 8'd20;
  localparam logic [LevelW-1:0] RST_MAX_LEVEL      = 8'd255;
  localparam logic [LevelW-1:0] RST_BRIGHTNESS     = 8'd255;

  typedef struct packed {
    logic [CntW-1:0]   debounce_ms;
    logic [CntW-1:0]   short_press_ms;
    logic [CntW-1:0]   long_press_ms;
    logic [CntW-1:0]   ramp_period_ms;
    logic [LevelW-1:0] min_level;
    logic [LevelW-1:0] max_level;
  } cfg_t;

  typedef struct packed {
    logic              clean_button;
    logic [CntW-1:0]   mismatch_count;
    logic [CntW-1:0]   hold_count;
    logic              is_held;
    logic [CntW-1:0]   ramp_count;
    logic              lamp_state;
    logic [LevelW-1:0] brightness;
    logic              ramp_upward;
  } state_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
  endfunction

endpackage

// File: hdl/bdc_step.sv
// ----------------------------------------------------------------------------
// bdc_step
// one millisecond tick of debounce, hold timing, ramping and release handling
// ----------------------------------------------------------------------------
module bdc_step (
  input  bdc_pkg::cfg_t   cfg,
  input  bdc_pkg::state_t cur,
  input  logic            button_level,
  output bdc_pkg::state_t nxt
);

  logic pressed_now;
  logic released_now;
  logic long_hold;
  logic short_ok;

  always_comb begin
    nxt          = cur;
    pressed_now  = 1'b0;
    released_now = 1'b0;

    // debounce
    if (button_level != cur.clean_button) begin
      nxt.mismatch_count = bdc_pkg::sat_inc(cur.mismatch_count);
      if (nxt.mismatch_count >= cfg.debounce_ms) begin
        nxt.clean_button   = button_level;
        nxt.mismatch_count = '0;
        pressed_now        = button_level;
        released_now       = !button_level;
      end
    end else begin
      nxt.mismatch_count = '0;
    end

    // hold timing
    if (pressed_now) begin
      nxt.is_held    = 1'b1;
      nxt.hold_count = '0;
    end else if (cur.is_held) begin
      nxt.hold_count = bdc_pkg::sat_inc(cur.hold_count);
    end

    nxt.ramp_count = bdc_pkg::sat_inc(cur.ramp_count);

    // long hold forces the lamp on and ramps
    long_hold = nxt.is_held && (nxt.hold_count >= cfg.long_press_ms);
    if (long_hold) begin
      nxt.lamp_state = 1'b1;
      if (nxt.ramp_count >= cfg.ramp_period_ms) begin
        if (cur.ramp_upward) begin
          if (cur.brightness < cfg.max_level) begin
            nxt.brightness = cur.brightness + 8'd1;
          end
        end else begin
          if (cur.brightness > cfg.min_level) begin
            nxt.brightness = cur.brightness - 8'd1;
          end
        end
        nxt.ramp_count = '0;
      end
    end

    // release
    short_ok = nxt.is_held && (nxt.hold_count >= cfg.short_press_ms)
               && (nxt.hold_count < cfg.long_press_ms);
    if (released_now) begin
      if (short_ok) begin
        nxt.lamp_state  = !nxt.lamp_state;
        nxt.ramp_upward = !cur.ramp_upward;
      end
      nxt.is_held = 1'b0;
    end
  end

endmodule

// File: hdl/button_dimmer_controller_core.sv
// ----------------------------------------------------------------------------
// button_dimmer_controller_core
// push-button dimmer: debounce, short press toggle, long press ramping
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one word per millisecond tick, the raw button level in bit 0
//   m_axis returns one word per input word: lamp enable and brightness
//   cfg_we/cfg_index/cfg_data write the six timing and level registers;
//   the user must write them only while the block is idle, not enforced here
// timing and throughput
//   a word is accepted every cycle unless a held result stalls the input;
//   its result is valid in the next cycle from the output register, the tick
//   update being a single pass of counter and compare logic
// reset
//   rst is synchronous; it loads the register defaults, releases the button,
//   turns the lamp off at full brightness with the ramp set to go down first
// stall
//   while m_axis_tready is low and a result is held, s_axis_tready is low;
//   the next word is taken in the same cycle the held result leaves
// ----------------------------------------------------------------------------
`include "button_dimmer_controller_core_defines.svh"

module button_dimmer_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] button_level, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] lamp_on, [8:1] lamp_level, [15:9] zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bdc_pkg::cfg_t   cfg;
  bdc_pkg::state_t state;
  bdc_pkg::state_t state_next;
  logic            in_acc;
  logic            lamp_on;
  logic [7:0]      lamp_level;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {7'd0, lamp_level, lamp_on};

  bdc_step u_step (
    .cfg          (cfg),
    .cur          (state),
    .button_level (s_axis_tdata[0]),
    .nxt          (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms    <= bdc_pkg::RST_DEBOUNCE_MS;
      cfg.short_press_ms <= bdc_pkg::RST_SHORT_PRESS_MS;
      cfg.long_press_ms  <= bdc_pkg::RST_LONG_PRESS_MS;
      cfg.ramp_period_ms <= bdc_pkg::RST_RAMP_PERIOD_MS;
      cfg.min_level      <= bdc_pkg::RST_MIN_LEVEL;
      cfg.max_level      <= bdc_pkg::RST_MAX_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        bdc_pkg::REG_DEBOUNCE_MS:    cfg.debounce_ms    <= cfg_data;
        bdc_pkg::REG_SHORT_PRESS_MS: cfg.short_press_ms <= cfg_data;
        bdc_pkg::REG_LONG_PRESS_MS:  cfg.long_press_ms  <= cfg_data;
        bdc_pkg::REG_RAMP_PERIOD_MS: cfg.ramp_period_ms <= cfg_data;
        bdc_pkg::REG_MIN_LEVEL:      cfg.min_level      <= cfg_data[7:0];
        bdc_pkg::REG_MAX_LEVEL:      cfg.max_level      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.clean_button   <= 1'b0;
      state.mismatch_count <= '0;
      state.hold_count     <= '0;
      state.is_held        <= 1'b0;
      state.ramp_count     <= '0;
      state.lamp_state     <= 1'b0;
      state.brightness     <= bdc_pkg::RST_BRIGHTNESS;
      state.ramp_upward    <= 1'b0;
      m_axis_tvalid        <= 1'b0;
    end else begin
      if (in_acc) begin
        state         <= state_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lamp_on    <= state_next.lamp_state;
      lamp_level <= state_next.brightness;
    end
  end

  `BDC_ASSERT_NEXT(a_state_only_on_accept, clk, rst, !in_acc, $stable(state))
  `BDC_ASSERT_NEXT(a_result_follows_accept, clk, rst, in_acc, m_axis_tvalid)
  `BDC_ASSERT_NOW(a_result_matches_state, clk, rst, m_axis_tvalid,
    lamp_on == state.lamp_state && lamp_level == state.brightness)
  `BDC_ASSERT_NEXT(a_brightness_single_step, clk, rst, in_acc,
    state.brightness == $past(state.brightness) ||
    state.brightness == 8'($past(state.brightness) + 8'd1) ||
    state.brightness == 8'($past(state.brightness) - 8'd1))

endmodule
